@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define JDSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define JDSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define JDSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/jdss_pkg.sv @@
// Types, constants and the segment table of the joystick digit editor.
package jdss_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int DIGITS     = 4;
    localparam int NIBBLE_W   = 4;
    localparam int VALUE_W    = DIGITS * NIBBLE_W;
    localparam int CURSOR_W   = 2;
    localparam int PULSES_W   = 2;
    localparam int SEG_W      = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 10'd896;
    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 10'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 1'b1;

    localparam logic [CURSOR_W-1:0] CURSOR_ONES      = 2'd0;
    localparam logic [CURSOR_W-1:0] CURSOR_THOUSANDS = 2'd3;

    localparam logic [NIBBLE_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [NIBBLE_W-1:0] DIGIT_MIN = 4'd0;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [VALUE_W-1:0]  value;
        logic [PULSES_W-1:0] pulses;
    } edit_result_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [NIBBLE_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 7'd119;
            4'd1:    pat = 7'd20;
            4'd2:    pat = 7'd91;
            4'd3:    pat = 7'd94;
            4'd4:    pat = 7'd60;
            4'd5:    pat = 7'd110;
            4'd6:    pat = 7'd111;
            4'd7:    pat = 7'd84;
            4'd8:    pat = 7'd127;
            4'd9:    pat = 7'd126;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

@@ hdl/jdss_edit.sv @@
// Clear, cursor move and digit change for one joystick item.
module jdss_edit import jdss_pkg::*; (
    input  logic [SAMPLE_W-1:0] x_sample,
    input  logic [SAMPLE_W-1:0] y_sample,
    input  logic                clear_button,
    input  logic [SAMPLE_W-1:0] high_threshold,
    input  logic [SAMPLE_W-1:0] low_threshold,
    input  logic [CURSOR_W-1:0] cursor,
    input  logic [VALUE_W-1:0]  value,
    output edit_result_t        result
);

    logic [CURSOR_W-1:0] cur_clr;
    logic [CURSOR_W-1:0] cur_new;
    logic [VALUE_W-1:0]  val_clr;
    logic [VALUE_W-1:0]  val_new;
    logic [NIBBLE_W-1:0] digit;
    logic                x_move;
    logic                y_move;

    always_comb begin
        cur_clr = clear_button ? CURSOR_ONES : cursor;
        val_clr = clear_button ? '0 : value;

        priority if (x_sample > high_threshold && cur_clr != CURSOR_ONES) begin
            cur_new = cur_clr - CURSOR_W'(1);
            x_move  = 1'b1;
        end else if (x_sample < low_threshold && cur_clr != CURSOR_THOUSANDS) begin
            cur_new = cur_clr + CURSOR_W'(1);
            x_move  = 1'b1;
        end else begin
            cur_new = cur_clr;
            x_move  = 1'b0;
        end

        digit   = val_clr[{cur_new, 2'b00} +: NIBBLE_W];
        val_new = val_clr;
        priority if (y_sample > high_threshold && digit != DIGIT_MAX) begin
            // count the push even on an out-of-range nibble, but leave it alone
            if (digit < DIGIT_MAX) begin
                val_new[{cur_new, 2'b00} +: NIBBLE_W] = digit + NIBBLE_W'(1);
            end
            y_move = 1'b1;
        end else if (y_sample < low_threshold && digit != DIGIT_MIN) begin
            val_new[{cur_new, 2'b00} +: NIBBLE_W] = digit - NIBBLE_W'(1);
            y_move = 1'b1;
        end else begin
            y_move = 1'b0;
        end

        result.cursor = cur_new;
        result.value  = val_new;
        result.pulses = PULSES_W'(clear_button) + PULSES_W'(x_move) + PULSES_W'(y_move);
    end

endmodule

@@ hdl/joystick_digit_editor_seven_segment_core.sv @@
// Joystick digit editor: edits a four digit BCD value and scans it onto a seven-segment display.
// Each input item carries one X/Y joystick sample pair and the clear level; it produces
// exactly one result item in the next cycle. The editing logic sits between the state
// registers and a single output register, so one item is accepted every cycle while the
// output is free or being taken; throughput is one item per clock when not stalled.
// Each item also steps the display scan by one digit, starting at the ones digit after
// reset. Thresholds are written through the cfg port (index 0 high, index 1 low) and take
// effect on the next item.
module joystick_digit_editor_seven_segment_core import jdss_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: x_sample[9:0], y_sample[19:10], clear_button[20], zero pad [23:21]
    input  logic [23:0]          s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata: segments[6:0], digit_lines[10:7], light_pulses[12:11],
    //          cursor_position[14:13], value_bcd[30:15], zero pad [31]
    output logic [31:0]          m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data
);

    logic [SAMPLE_W-1:0] high_thr_reg;
    logic [SAMPLE_W-1:0] low_thr_reg;
    logic [CURSOR_W-1:0] cursor_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [1:0]          scan_reg;
    logic                m_valid_reg;
    logic [31:0]         m_data_reg;
    logic [31:0]         m_data_next;
    logic                s_accept;
    edit_result_t        edit;
    logic [NIBBLE_W-1:0] scan_digit;
    logic [3:0]          digit_lines;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    jdss_edit u_edit (
        .x_sample       (s_tdata[9:0]),
        .y_sample       (s_tdata[19:10]),
        .clear_button   (s_tdata[20]),
        .high_threshold (high_thr_reg),
        .low_threshold  (low_thr_reg),
        .cursor         (cursor_reg),
        .value          (value_reg),
        .result         (edit)
    );

    always_comb begin
        scan_digit  = edit.value[{scan_reg, 2'b00} +: NIBBLE_W];
        digit_lines = ~(4'b1000 >> scan_reg);
        m_data_next = {1'b0, edit.value, edit.cursor, edit.pulses, digit_lines,
                       seg_pattern(scan_digit)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg <= HIGH_THRESHOLD_RST;
            low_thr_reg  <= LOW_THRESHOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HIGH_THRESHOLD: high_thr_reg <= cfg_data;
                CFG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= '0;
            value_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                cursor_reg  <= edit.cursor;
                value_reg   <= edit.value;
                scan_reg    <= scan_reg + 2'd1;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                // drop the result once taken
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

@@ hdl/jdss_checker.sv @@
// Port-level checks for the joystick digit editor core, bound to the top level.
`include "assert_macros.svh"

module jdss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic [31:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    `JDSS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result item changed while stalled")
    `JDSS_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready,
        "input stalled with empty output")
    `JDSS_ASSERT_SAME(a_one_digit_line, aclk, aresetn, m_tvalid, $onehot(~m_tdata[10:7]),
        "digit lines not a single active-low enable")
    `JDSS_ASSERT_SAME(a_bcd_digits, aclk, aresetn, m_tvalid,
        (m_tdata[18:15] <= 4'd9) && (m_tdata[22:19] <= 4'd9) &&
        (m_tdata[26:23] <= 4'd9) && (m_tdata[30:27] <= 4'd9), "value nibble above nine")

endmodule

bind joystick_digit_editor_seven_segment_core jdss_checker u_jdss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
